// File: rtl/core/block_pool_allocator_top_assert.svh
// Assertion helpers for the pool allocator.
`ifndef BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH
`define BLOCK_POOL_ALLOCATOR_TOP_ASSERT_SVH

`define BPA_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

`define BPA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/bpa_pkg.sv
package bpa_pkg;

	localparam int ID_W     = 16;
	localparam int BYTES_W  = 25;
	localparam int IDX_W    = 4;
	localparam int PLACED_W = 5;
	localparam int REQ_W    = 3;
	localparam int STAT_W   = 2;
	localparam int REM_W    = BYTES_W + 1;

	localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_FREE    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_MERGE   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_COMPACT = 3'd3;
	localparam logic [REQ_W-1:0] REQ_READ    = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_SIZE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [BYTES_W-1:0] alloc_bytes;
		logic [ID_W-1:0]    id_a;
		logic [ID_W-1:0]    id_b;
		logic [ID_W-1:0]    id_c;
		logic [IDX_W-1:0]   slot_index;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [ID_W-1:0]     assigned_id;
		logic [PLACED_W-1:0] blocks_placed;
		logic [ID_W-1:0]     read_id;
		logic                read_in_use;
		logic                read_free;
	} rsp_t;

	typedef struct packed {
		logic            free;
		logic [ID_W-1:0] owner;
	} slot_t;

	localparam slot_t SLOT_EMPTY = '{free: 1'b1, owner: '0};

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_ALLOC,
		CELL_FREE,
		CELL_MERGE,
		CELL_SORT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t        op;
		logic            odd;
		logic [ID_W-1:0] id_a;
		logic [ID_W-1:0] id_b;
		logic [ID_W-1:0] id_c;
		logic [ID_W-1:0] new_id;
	} cell_cmd_t;

	typedef struct packed {
		logic               done;
		logic               rem_nz;
		logic [BYTES_W-1:0] quot;
	} div_res_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ALLOC,
		S_EXEC,
		S_SORT,
		S_ROTATE,
		S_EMIT
	} state_t;

endpackage

// File: rtl/core/bpa_if.sv
interface bpa_req_if;
	logic          valid;
	logic          ready;
	bpa_pkg::req_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bpa_rsp_if;
	logic          valid;
	logic          ready;
	bpa_pkg::rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/bpa_cell.sv
module bpa_cell #(
	parameter int INDEX = 0,
	parameter int SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpa_pkg::cell_cmd_t cmd,
	input  logic               alloc_hit,
	input  bpa_pkg::slot_t     left,
	input  bpa_pkg::slot_t     right,
	output bpa_pkg::slot_t     slot
);
	import bpa_pkg::*;

	localparam logic IS_ODD    = (INDEX % 2) == 1;
	localparam logic HAS_LEFT  = INDEX > 0;
	localparam logic HAS_RIGHT = INDEX < SLOTS - 1;

	slot_t slot_q;
	slot_t slot_d;

	always_comb begin
		slot_d = slot_q;
		case (cmd.op)
			CELL_ALLOC: begin
				if (alloc_hit) begin
					slot_d.free  = 1'b0;
					slot_d.owner = cmd.new_id;
				end
			end
			CELL_FREE: begin
				if (!slot_q.free && slot_q.owner == cmd.id_a) begin
					slot_d = SLOT_EMPTY;
				end
			end
			CELL_MERGE: begin
				if (!slot_q.free && (slot_q.owner == cmd.id_a || slot_q.owner == cmd.id_b)) begin
					slot_d.owner = cmd.id_c;
				end
			end
			CELL_SORT: begin
				// odd-even transposition: free slots sink, used slots rise, order kept
				if (IS_ODD == cmd.odd) begin
					if (HAS_RIGHT && slot_q.free && !right.free) begin
						slot_d = right;
					end
				end else begin
					if (HAS_LEFT && left.free && !slot_q.free) begin
						slot_d = left;
					end
				end
			end
			CELL_ROTATE: begin
				slot_d = right;
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_EMPTY;
		end else begin
			slot_q <= slot_d;
		end
	end

	assign slot = slot_q;

endmodule

// File: rtl/core/bpa_div.sv
module bpa_div #(
	parameter int DIVISOR = 1048576
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bpa_pkg::BYTES_W-1:0]   dividend,
	output bpa_pkg::div_res_t             res
);
	import bpa_pkg::*;

	localparam int               PROD_W = 2 * BYTES_W;
	localparam logic [REM_W-1:0] DIV_C  = REM_W'(DIVISOR);
	localparam logic [REM_W-1:0] RECIP  = REM_W'((64'd1 << BYTES_W) / DIVISOR);

	logic               v_s1;
	logic               v_s2;
	logic               v_s3;
	logic               done_q;
	logic [BYTES_W-1:0] dvd_s1;
	logic [BYTES_W-1:0] dvd_s2;
	logic [BYTES_W-1:0] q_s2;
	logic [BYTES_W-1:0] q_s3;
	logic [REM_W-1:0]   rem_s3;
	logic [BYTES_W-1:0] quot_q;
	logic               rem_nz_q;
	logic [PROD_W-1:0]  prod;
	logic [REM_W-1:0]   back;
	logic               ge;

	// reciprocal estimate is low by at most one; one correction step fixes it
	always_comb begin
		prod = PROD_W'(dvd_s1) * PROD_W'(RECIP);
		back = REM_W'(q_s2) * DIV_C;
		ge   = rem_s3 >= DIV_C;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			done_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_s1 <= dividend;
		end
		if (v_s1) begin
			q_s2   <= prod[PROD_W-1:BYTES_W];
			dvd_s2 <= dvd_s1;
		end
		if (v_s2) begin
			q_s3   <= q_s2;
			rem_s3 <= REM_W'(dvd_s2) - back;
		end
		if (v_s3) begin
			quot_q   <= ge ? (q_s3 + 1'b1) : q_s3;
			rem_nz_q <= ge ? (rem_s3 != DIV_C) : (rem_s3 != '0);
		end
	end

	assign res.done   = done_q;
	assign res.rem_nz = rem_nz_q;
	assign res.quot   = quot_q;

endmodule

// File: rtl/core/block_pool_allocator_top.sv
// From accepted beat to result beat: free and merge run one cell command, an in-range read a
// full rotation, compact a sort pass then a full rotation, allocate the 4-stage reciprocal size
// divider and one cell write (not on a bad size); out-of-range read, unknown request: none.
// One request in flight; the next is taken as soon as the previous result is in the output reg.
// Rate is set by the row's shift passes (sort, then full rotation), divider stages, rsp.ready.
// Reset (async, active low): all slots free with owner 0, fill pointer 0, next id 1.
module block_pool_allocator_top #(
	parameter int SLOT_COUNT  = 16,
	parameter int BLOCK_BYTES = 1048576
) (
	input logic        clk,
	input logic        arst_n,
	bpa_req_if.sink    req,
	bpa_rsp_if.source  rsp
);
	import bpa_pkg::*;
	`include "block_pool_allocator_top_assert.svh"

	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int STEP_W = $clog2(SLOT_COUNT);
	localparam int WIDE_W = CNT_W + IDX_W;
	localparam int SUM_W  = CNT_W + 1;
	localparam int EXT_W  = CNT_W + PLACED_W;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SLOT_COUNT - 1);

	state_t             state_q;
	state_t             state_d;
	logic [STEP_W-1:0]  step_q;
	logic [STEP_W-1:0]  step_d;
	req_t               req_q;
	rsp_t               res_q;
	rsp_t               out_q;
	logic               out_v_q;
	logic [CNT_W-1:0]   fill_q;
	logic [ID_W-1:0]    next_id_q;
	logic [CNT_W-1:0]   n_q;
	logic [CNT_W-1:0]   used_q;

	logic               accept;
	logic               div_start;
	logic               emit;
	logic               in_range;
	rsp_t               res_init;
	cell_cmd_t          cmd;
	div_res_t           div_res;
	slot_t              slots [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] alloc_hit;

	logic [CNT_W-1:0]   room;
	logic               want_gt;
	logic [CNT_W-1:0]   n_calc;
	logic [EXT_W-1:0]   n_ext;
	logic               head_used;

	assign accept    = req.valid && req.ready;
	assign req.ready = state_q == S_IDLE;
	assign in_range  = WIDE_W'(req.payload.slot_index) < WIDE_W'(SLOT_COUNT);
	assign head_used = !slots[0].free;

	assign room    = CNT_W'(SLOT_COUNT) - fill_q;
	assign want_gt = div_res.quot > BYTES_W'(room);
	assign n_calc  = want_gt ? room : CNT_W'(div_res.quot);
	assign n_ext   = EXT_W'(n_calc);

	always_comb begin
		res_init           = '0;
		res_init.read_free = req.payload.req_type == REQ_READ && !in_range;
	end

	bpa_div #(
		.DIVISOR (BLOCK_BYTES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.payload.alloc_bytes),
		.res      (div_res)
	);

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		localparam int L = (i == 0) ? SLOT_COUNT - 1 : i - 1;
		localparam int R = (i == SLOT_COUNT - 1) ? 0 : i + 1;

		assign alloc_hit[i] = (SUM_W'(i) >= SUM_W'(fill_q))
			&& (SUM_W'(i) < SUM_W'(fill_q) + SUM_W'(n_q));

		bpa_cell #(
			.INDEX (i),
			.SLOTS (SLOT_COUNT)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.alloc_hit (alloc_hit[i]),
			.left      (slots[L]),
			.right     (slots[R]),
			.slot      (slots[i])
		);
	end

	always_comb begin
		state_d    = state_q;
		step_d     = step_q;
		div_start  = 1'b0;
		emit       = 1'b0;
		cmd.op     = CELL_HOLD;
		cmd.odd    = step_q[0];
		cmd.id_a   = req_q.id_a;
		cmd.id_b   = req_q.id_b;
		cmd.id_c   = req_q.id_c;
		cmd.new_id = next_id_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					step_d = '0;
					case (req.payload.req_type)
						REQ_ALLOC: begin
							state_d   = S_DIV;
							div_start = 1'b1;
						end
						REQ_FREE, REQ_MERGE: state_d = S_EXEC;
						REQ_COMPACT:         state_d = S_SORT;
						REQ_READ:            state_d = in_range ? S_ROTATE : S_EMIT;
						default:             state_d = S_EMIT;
					endcase
				end
			end
			S_DIV: begin
				if (div_res.done) begin
					state_d = div_res.rem_nz ? S_EMIT : S_ALLOC;
				end
			end
			S_ALLOC: begin
				cmd.op  = CELL_ALLOC;
				state_d = S_EMIT;
			end
			S_EXEC: begin
				cmd.op  = (req_q.req_type == REQ_FREE) ? CELL_FREE : CELL_MERGE;
				state_d = S_EMIT;
			end
			S_SORT: begin
				cmd.op = CELL_SORT;
				if (step_q == STEP_LAST) begin
					step_d  = '0;
					state_d = S_ROTATE;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_ROTATE: begin
				cmd.op = CELL_ROTATE;
				if (step_q == STEP_LAST) begin
					state_d = S_EMIT;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			S_EMIT: begin
				if (!out_v_q || rsp.ready) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			fill_q    <= '0;
			next_id_q <= ID_W'(1);
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			if (state_q == S_ALLOC) begin
				fill_q    <= fill_q + n_q;
				next_id_q <= next_id_q + 1'b1;
			end
			if (state_q == S_ROTATE && step_q == STEP_LAST && req_q.req_type == REQ_COMPACT) begin
				fill_q <= used_q + CNT_W'(head_used);
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= req.payload;
			res_q  <= res_init;
			used_q <= '0;
		end
		if (state_q == S_DIV && div_res.done) begin
			if (div_res.rem_nz) begin
				res_q.status <= STAT_BAD_SIZE;
			end else begin
				n_q                 <= n_calc;
				res_q.status        <= want_gt ? STAT_FULL : STAT_OK;
				res_q.assigned_id   <= next_id_q;
				res_q.blocks_placed <= n_ext[PLACED_W-1:0];
			end
		end
		if (state_q == S_ROTATE) begin
			used_q <= used_q + CNT_W'(head_used);
			if (req_q.req_type == REQ_READ && WIDE_W'(step_q) == WIDE_W'(req_q.slot_index)) begin
				res_q.read_id     <= slots[0].owner;
				res_q.read_free   <= slots[0].free;
				res_q.read_in_use <= WIDE_W'(req_q.slot_index) < WIDE_W'(fill_q);
			end
		end
		if (emit) begin
			out_q <= res_q;
		end
	end

	assign rsp.valid   = out_v_q;
	assign rsp.payload = out_q;

	`BPA_ASSERT_ALWAYS(a_fill_bound, fill_q <= CNT_W'(SLOT_COUNT), "fill pointer past pool end")
	`BPA_ASSERT_NEXT(a_alloc_fill, state_q == S_ALLOC, fill_q == $past(fill_q) + $past(n_q), "fill pointer did not advance by placed count")
	`BPA_ASSERT_IMPL(a_div_done, div_res.done, state_q == S_DIV, "divider finished outside allocate")
	`BPA_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_q != S_IDLE, "accepted beat left no work")

endmodule

// File: bench/bpa_check_pkg.sv
package bpa_check_pkg;

	import bpa_pkg::*;

	localparam int POOL_SLOTS = 16;
	localparam int BLOCK_SIZE = 1048576;

	class pool_tracker;
		logic [ID_W-1:0] slot_owner [POOL_SLOTS];
		bit              slot_free [POOL_SLOTS];
		int unsigned     fill;
		logic [ID_W-1:0] next_id;
		rsp_t            awaited_rsp [$];
		int unsigned     mismatches;

		function new();
			for (int i = 0; i < POOL_SLOTS; i++) begin
				slot_owner[i] = '0;
				slot_free[i]  = 1'b1;
			end
			fill        = 0;
			next_id     = 16'd1;
			mismatches  = 0;
		endfunction

		// random owner of a slot in use, or a random id if none is in use
		function logic [ID_W-1:0] live_id();
			int unsigned used [$];
			for (int i = 0; i < fill; i++)
				if (!slot_free[i])
					used.push_back(i);
			if (used.size() == 0)
				return ID_W'($urandom);
			return slot_owner[used[$urandom_range(0, used.size() - 1)]];
		endfunction

		function void note_request(req_t r);
			rsp_t        e;
			int unsigned want;
			int unsigned n;
			int unsigned w;
			e = '0;
			case (r.req_type)
				REQ_ALLOC: begin
					if (r.alloc_bytes % BLOCK_SIZE != 0) begin
						e.status = STAT_BAD_SIZE;
					end else begin
						want = r.alloc_bytes / BLOCK_SIZE;
						n    = 0;
						while (n < want && fill < POOL_SLOTS) begin
							slot_owner[fill] = next_id;
							slot_free[fill]  = 1'b0;
							fill++;
							n++;
						end
						e.status        = (n < want) ? STAT_FULL : STAT_OK;
						e.assigned_id   = next_id;
						e.blocks_placed = PLACED_W'(n);
						next_id         = next_id + 16'd1;
					end
				end
				REQ_FREE: begin
					for (int i = 0; i < fill; i++)
						if (!slot_free[i] && slot_owner[i] == r.id_a) begin
							slot_free[i]  = 1'b1;
							slot_owner[i] = '0;
						end
				end
				REQ_MERGE: begin
					for (int i = 0; i < fill; i++)
						if (!slot_free[i] && (slot_owner[i] == r.id_a || slot_owner[i] == r.id_b))
							slot_owner[i] = r.id_c;
				end
				REQ_COMPACT: begin
					w = 0;
					for (int i = 0; i < fill; i++)
						if (!slot_free[i]) begin
							slot_owner[w] = slot_owner[i];
							slot_free[w]  = 1'b0;
							w++;
						end
					for (int i = w; i < POOL_SLOTS; i++) begin
						slot_owner[i] = '0;
						slot_free[i]  = 1'b1;
					end
					fill = w;
				end
				REQ_READ: begin
					if (r.slot_index < POOL_SLOTS) begin
						e.read_id     = slot_owner[r.slot_index];
						e.read_in_use = (r.slot_index < fill);
						e.read_free   = slot_free[r.slot_index];
					end else begin
						e.read_free = 1'b1;
					end
				end
				default: ;
			endcase
			awaited_rsp.push_back(e);
		endfunction

		function string fmt(rsp_t p);
			return $sformatf("status=%0d id=%0d placed=%0d rid=%0d in_use=%0d free=%0d",
				p.status, p.assigned_id, p.blocks_placed, p.read_id, p.read_in_use,
				p.read_free);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("%s", msg);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (awaited_rsp.size() == 0) begin
				flag($sformatf("mismatch: unexpected result beat %s", fmt(got)));
				return;
			end
			e = awaited_rsp.pop_front();
			if (got.status !== e.status || got.assigned_id !== e.assigned_id ||
			    got.blocks_placed !== e.blocks_placed || got.read_id !== e.read_id ||
			    got.read_in_use !== e.read_in_use || got.read_free !== e.read_free)
				flag($sformatf("mismatch: expected %s, got %s", fmt(e), fmt(got)));
		endfunction
	endclass

endpackage

// File: bench/block_pool_allocator_top_test.sv
module block_pool_allocator_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	import bpa_pkg::*;
	import bpa_check_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	bit   idle_on;
	bit   stall_on;

	pool_tracker pool = new();

	bpa_req_if req_if ();
	bpa_rsp_if rsp_if ();

	block_pool_allocator_top #(
		.SLOT_COUNT  (POOL_SLOTS),
		.BLOCK_BYTES (BLOCK_SIZE)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #2 clk = ~clk;

	function automatic req_t with_type(logic [REQ_W-1:0] t);
		req_t r;
		r.req_type    = t;
		r.alloc_bytes = BYTES_W'($urandom);
		r.id_a        = ID_W'($urandom);
		r.id_b        = ID_W'($urandom);
		r.id_c        = ID_W'($urandom);
		r.slot_index  = IDX_W'($urandom);
		return r;
	endfunction

	function automatic req_t mk_alloc(logic [BYTES_W-1:0] bytes);
		req_t r;
		r             = with_type(REQ_ALLOC);
		r.alloc_bytes = bytes;
		return r;
	endfunction

	function automatic req_t mk_free(logic [ID_W-1:0] a);
		req_t r;
		r      = with_type(REQ_FREE);
		r.id_a = a;
		return r;
	endfunction

	function automatic req_t mk_merge(logic [ID_W-1:0] a, logic [ID_W-1:0] b,
	                                  logic [ID_W-1:0] c);
		req_t r;
		r      = with_type(REQ_MERGE);
		r.id_a = a;
		r.id_b = b;
		r.id_c = c;
		return r;
	endfunction

	function automatic req_t mk_read(logic [IDX_W-1:0] idx);
		req_t r;
		r            = with_type(REQ_READ);
		r.slot_index = idx;
		return r;
	endfunction

	task automatic issue(req_t r);
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		pool.note_request(r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (pool.awaited_rsp.size() != 0)
			@(posedge clk);
	endtask

	// receive side: ready drops in random bursts while stalls are on
	initial begin
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_on && $urandom_range(0, 7) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
			pool.check_response(rsp_if.payload);

	initial begin
		req_t            r;
		logic [ID_W-1:0] id_x;
		logic [ID_W-1:0] id_y;
		logic [ID_W-1:0] id_z;
		int unsigned     pick;
		int unsigned     k;

		req_if.valid   <= 1'b0;
		req_if.payload <= '0;
		arst_n         <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_on  = 1'b1;
		stall_on = 1'b1;

		issue(mk_read(0));
		issue(mk_alloc(0));
		issue(mk_alloc(1));
		issue(mk_alloc('1));
		issue(mk_alloc(BYTES_W'(3 * BLOCK_SIZE)));
		id_x = pool.next_id - 16'd1;
		issue(mk_alloc(BYTES_W'(BLOCK_SIZE)));
		id_y = pool.next_id - 16'd1;
		issue(mk_alloc(BYTES_W'(4 * BLOCK_SIZE)));
		id_z = pool.next_id - 16'd1;
		issue(mk_free(id_y));
		issue(mk_merge(id_x, id_z, 16'hFFFF));
		// freed slots carry owner 0 and must stay untouched
		issue(mk_merge(16'h0000, 16'h0000, 16'h1234));
		issue(mk_read(3));
		issue(mk_read(4));
		issue(with_type(REQ_COMPACT));
		issue(mk_read(15));
		issue(mk_alloc(BYTES_W'(31 * BLOCK_SIZE)));
		issue(mk_read(15));
		issue(mk_free(16'hFFFF));
		issue(with_type(REQ_COMPACT));
		for (int t = 1; t <= 3; t++)
			issue(with_type(REQ_W'(REQ_READ + t)));
		issue(mk_alloc(BYTES_W'(16 * BLOCK_SIZE)));
		issue(mk_alloc(BYTES_W'(BLOCK_SIZE)));
		issue(mk_free(pool.next_id - 16'd2));
		issue(with_type(REQ_COMPACT));

		for (int i = 0; i < 1000; i++) begin
			idle_on  = (i < 800) && ((i / 100) % 3 != 2);
			stall_on = idle_on;
			if (i == 400)
				drain();
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				k = $urandom_range(0, 19);
				if (k < 3)
					r = mk_alloc(BYTES_W'($urandom));
				else if (k < 17)
					r = mk_alloc(BYTES_W'($urandom_range(0, 4) * BLOCK_SIZE));
				else
					r = mk_alloc(BYTES_W'($urandom_range(5, 31) * BLOCK_SIZE));
			end else if (pick < 50) begin
				r = mk_free(($urandom_range(0, 4) == 0) ? ID_W'($urandom) : pool.live_id());
			end else if (pick < 65) begin
				r = mk_merge(pool.live_id(),
					($urandom_range(0, 3) == 0) ? ID_W'($urandom) : pool.live_id(),
					($urandom_range(0, 1) == 0) ? ID_W'($urandom) : pool.live_id());
			end else if (pick < 75) begin
				r = with_type(REQ_COMPACT);
			end else if (pick < 95) begin
				r = mk_read(IDX_W'($urandom));
			end else begin
				r = with_type(REQ_W'(REQ_READ + $urandom_range(1, 3)));
			end
			issue(r);
		end

		drain();
		repeat (2 * POOL_SLOTS + 8) @(posedge clk);
		if (pool.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/bpa_pkg.sv
rtl/core/bpa_if.sv
rtl/core/bpa_cell.sv
rtl/core/bpa_div.sv
rtl/core/block_pool_allocator_top.sv
bench/bpa_check_pkg.sv
bench/block_pool_allocator_top_test.sv
